// ----- rtl/lnorm_pkg.sv -----
// Shared types and constants for the layer normalisation block.
package lnorm_pkg;

   // Payload word and stored row word {offset, gain, sample}
   localparam int WORD_W = 32;
   localparam int RAM_W  = 3 * WORD_W;

   // Configuration port
   localparam int CSR_IDX_W  = 4;
   localparam int CSR_DATA_W = 16;
   localparam int ROWLEN_W   = 7;
   localparam int EPS_W      = 16;

   localparam logic [CSR_IDX_W-1:0] CSR_ROW_LENGTH = CSR_IDX_W'(0);
   localparam logic [CSR_IDX_W-1:0] CSR_EPSILON    = CSR_IDX_W'(1);

   localparam logic [ROWLEN_W-1:0] ROWLEN_RESET = ROWLEN_W'(64);
   localparam logic [EPS_W-1:0]    EPS_RESET    = EPS_W'(1);

   // Shared restoring divider: 64-bit dividend, 32-bit divisor, one bit a cycle
   localparam int DIVIDEND_W = 64;
   localparam int DIVISOR_W  = 32;
   localparam int DIV_STEPS  = DIVIDEND_W;
   localparam int DIV_CNT_W  = $clog2(DIV_STEPS);

   // Square root: 64-bit radicand, 32-bit root, two radicand bits a cycle
   localparam int RADICAND_W = 64;
   localparam int ROOT_W     = 32;
   localparam int SQRT_STEPS = ROOT_W;
   localparam int SQRT_CNT_W = $clog2(SQRT_STEPS);

   // Q32.16 squared deviation after the fraction shift, and the variance
   localparam int SQ_W  = 2 * WORD_W - 16;
   localparam int VAR_W = SQ_W;

   // Row sequencer
   typedef enum logic [4:0] {
      ST_FILL,
      ST_SUM_RD,
      ST_SUM_ACC,
      ST_MEAN_GO,
      ST_MEAN_WAIT,
      ST_VAR_RD,
      ST_VAR_DIF,
      ST_VAR_MUL,
      ST_VAR_ACC,
      ST_VDIV_GO,
      ST_VDIV_WAIT,
      ST_SQRT_GO,
      ST_SQRT_WAIT,
      ST_NRM_RD,
      ST_NRM_DIF,
      ST_NDIV_GO,
      ST_NDIV_WAIT,
      ST_NRM_MUL,
      ST_NRM_ADD,
      ST_NRM_OUT
   } lnorm_state_type;

endpackage

// ----- rtl/lnorm_if.sv -----
// Valid/ready channel interfaces for row elements in and normalised results out.
interface lnorm_req_if import lnorm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] sample;
   logic [WORD_W-1:0] scale;
   logic [WORD_W-1:0] shift;

   modport source (output valid, output sample, output scale, output shift, input ready);
   modport sink   (input valid, input sample, input scale, input shift, output ready);
endinterface

interface lnorm_rsp_if import lnorm_pkg::*; ();
   logic              valid;
   logic              ready;
   logic [WORD_W-1:0] value;
   logic              last;

   modport source (output valid, output value, output last, input ready);
   modport sink   (input valid, input value, input last, output ready);
endinterface

// ----- rtl/lnorm_ram.sv -----
// Generic single-port-write, single-port-read RAM with registered read data.
module lnorm_ram #(
   parameter int WIDTH = 8,
   parameter int DEPTH = 16
) (
   input  logic                     clock,
   input  logic                     wr_en,
   input  logic [$clog2(DEPTH)-1:0] wr_addr,
   input  logic [WIDTH-1:0]         wr_data,
   input  logic [$clog2(DEPTH)-1:0] rd_addr,
   output logic [WIDTH-1:0]         rd_data
);

   logic [WIDTH-1:0] mem_ff [DEPTH];
   logic [WIDTH-1:0] rd_data_ff;

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_ff[wr_addr] <= wr_data;
      end
      rd_data_ff <= mem_ff[rd_addr];
   end

   assign rd_data = rd_data_ff;

endmodule

// ----- rtl/lnorm_div.sv -----
// Shared unsigned restoring divider, one quotient bit per cycle.
module lnorm_div import lnorm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [DIVIDEND_W-1:0] dividend,
   input  logic [DIVISOR_W-1:0]  divisor,
   output logic                  done,
   output logic [DIVIDEND_W-1:0] quotient
);

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [DIV_CNT_W-1:0]  cnt_ff, cnt_in;
   logic [DIVIDEND_W-1:0] quo_ff, quo_in;
   logic [DIVISOR_W-1:0]  rem_ff, rem_in;
   logic [DIVISOR_W-1:0]  dsr_ff, dsr_in;

   logic [DIVISOR_W:0]    shifted;
   logic [DIVISOR_W:0]    diff;
   logic                  ge;

   // One trial subtraction
   always_comb begin
      shifted = {rem_ff, quo_ff[DIVIDEND_W-1]};
      ge      = (shifted >= {1'b0, dsr_ff});
      diff    = shifted - {1'b0, dsr_ff};
   end

   // Load on start, then shift the quotient in bit by bit
   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      quo_in  = quo_ff;
      rem_in  = rem_ff;
      dsr_in  = dsr_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         quo_in  = dividend;
         rem_in  = '0;
         dsr_in  = divisor;
      end else if (busy_ff) begin
         quo_in = {quo_ff[DIVIDEND_W-2:0], ge};
         rem_in = ge ? diff[DIVISOR_W-1:0] : shifted[DIVISOR_W-1:0];
         cnt_in = cnt_ff + DIV_CNT_W'(1);
         if (cnt_ff == DIV_CNT_W'(DIV_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      quo_ff <= quo_in;
      rem_ff <= rem_in;
      dsr_ff <= dsr_in;
   end

   assign done     = done_ff;
   assign quotient = quo_ff;

endmodule

// ----- rtl/lnorm_sqrt.sv -----
// Integer square root (floor), two radicand bits per cycle.
module lnorm_sqrt import lnorm_pkg::*; (
   input  logic                  clock,
   input  logic                  reset,
   input  logic                  start,
   input  logic [RADICAND_W-1:0] radicand,
   output logic                  done,
   output logic [ROOT_W-1:0]     root
);

   localparam int REM_W = ROOT_W + 2;

   logic                  busy_ff, busy_in;
   logic                  done_ff, done_in;
   logic [SQRT_CNT_W-1:0] cnt_ff, cnt_in;
   logic [RADICAND_W-1:0] rad_ff, rad_in;
   logic [REM_W-1:0]      rem_ff, rem_in;
   logic [ROOT_W-1:0]     root_ff, root_in;

   logic [REM_W+1:0]      rem_sh;
   logic [REM_W+1:0]      trial;
   logic [REM_W+1:0]      diff;
   logic                  ge;

   // Bring down two bits and try root*4+1
   always_comb begin
      rem_sh = {rem_ff, rad_ff[RADICAND_W-1 -: 2]};
      trial  = {2'b00, root_ff, 2'b01};
      ge     = (rem_sh >= trial);
      diff   = rem_sh - trial;
   end

   always_comb begin
      busy_in = busy_ff;
      done_in = 1'b0;
      cnt_in  = cnt_ff;
      rad_in  = rad_ff;
      rem_in  = rem_ff;
      root_in = root_ff;
      if (start) begin
         busy_in = 1'b1;
         cnt_in  = '0;
         rad_in  = radicand;
         rem_in  = '0;
         root_in = '0;
      end else if (busy_ff) begin
         rad_in  = {rad_ff[RADICAND_W-3:0], 2'b00};
         rem_in  = ge ? diff[REM_W-1:0] : rem_sh[REM_W-1:0];
         root_in = {root_ff[ROOT_W-2:0], ge};
         cnt_in  = cnt_ff + SQRT_CNT_W'(1);
         if (cnt_ff == SQRT_CNT_W'(SQRT_STEPS - 1)) begin
            busy_in = 1'b0;
            done_in = 1'b1;
         end
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         busy_ff <= 1'b0;
         done_ff <= 1'b0;
         cnt_ff  <= '0;
      end else begin
         busy_ff <= busy_in;
         done_ff <= done_in;
         cnt_ff  <= cnt_in;
      end
   end

   always_ff @(posedge clock) begin
      rad_ff  <= rad_in;
      rem_ff  <= rem_in;
      root_ff <= root_in;
   end

   assign done = done_ff;
   assign root = root_ff;

endmodule

// ----- rtl/layer_normalization.sv -----
// Layer normalisation of one row: one item a cycle while filling (n items of the row).
// After the last item the first result waits on the shared 64-step divider (mean, variance,
// one division per element) and the 32-step root. Results then follow one by one (one
// division each, none when sd is zero). Synchronous reset clears the sequencer, fill count
// and configuration registers (row_length 64, epsilon 1); the row store is not cleared and
// is written before read.
module layer_normalization import lnorm_pkg::*; #(
   parameter int MAX_ROW    = 64,
   parameter int DATA_WIDTH = 32
) (
   input  logic                  clock,
   input  logic                  reset,
   lnorm_req_if.sink             req_ch,
   lnorm_rsp_if.source           rsp_ch,
   input  logic                  csr_we,
   input  logic [CSR_IDX_W-1:0]  csr_index,
   input  logic [CSR_DATA_W-1:0] csr_wdata
);

   localparam int ADDR_W = $clog2(MAX_ROW);
   localparam int LEN_W  = $clog2(MAX_ROW + 1);
   localparam int EXT    = WORD_W - DATA_WIDTH;
   localparam int SUM_W  = WORD_W + LEN_W;
   localparam int VSUM_W = SQ_W + LEN_W;
   localparam int PM_W   = 2 * WORD_W - 16;
   localparam int RES_W  = PM_W + 2;

   localparam logic signed [RES_W-1:0] SAT_HI = RES_W'((64'sd1 <<< (DATA_WIDTH - 1)) - 64'sd1);
   localparam logic signed [RES_W-1:0] SAT_LO = -SAT_HI - RES_W'(1);

   // Sign-extend a word from the configured data width
   function automatic logic [WORD_W-1:0] sext_dw(input logic [WORD_W-1:0] x);
      logic signed [WORD_W-1:0] t;
      t = $signed(x) <<< EXT;
      return t >>> EXT;
   endfunction

   lnorm_state_type state_ff, state_in;

   logic [ROWLEN_W-1:0]      row_len_ff, row_len_in;
   logic [EPS_W-1:0]         eps_ff, eps_in;
   logic [ADDR_W-1:0]        fill_ff, fill_in;
   logic [ADDR_W-1:0]        idx_ff, idx_in;
   logic signed [SUM_W-1:0]  sum_ff, sum_in;
   logic signed [WORD_W-1:0] mean_ff, mean_in;
   logic [WORD_W-1:0]        dmag_ff, dmag_in;
   logic                     dneg_ff, dneg_in;
   logic [2*WORD_W-1:0]      prod_ff, prod_in;
   logic [VSUM_W-1:0]        vsum_ff, vsum_in;
   logic [VAR_W-1:0]         var_ff, var_in;
   logic [ROOT_W-1:0]        sd_ff, sd_in;
   logic [WORD_W-1:0]        gmag_ff, gmag_in;
   logic                     gneg_ff, gneg_in;
   logic signed [WORD_W-1:0] off_ff, off_in;
   logic [WORD_W-1:0]        nm_ff, nm_in;
   logic [WORD_W-1:0]        value_ff, value_in;
   logic                     last_ff, last_in;

   logic [LEN_W-1:0]         n_eff;
   logic [LEN_W-1:0]         fill_next;
   logic                     row_done;
   logic                     idx_last;
   logic                     req_fire;
   logic                     rsp_fire;
   logic                     sd_zero;

   logic                     ram_we;
   logic [RAM_W-1:0]         ram_wdata;
   logic [RAM_W-1:0]         ram_rdata;
   logic [WORD_W-1:0]        rd_sample;
   logic [WORD_W-1:0]        rd_gain;
   logic [WORD_W-1:0]        rd_off;

   logic                     div_start;
   logic [DIVIDEND_W-1:0]    div_dividend;
   logic [DIVISOR_W-1:0]     div_divisor;
   logic                     div_done;
   logic [DIVIDEND_W-1:0]    div_quo;

   logic                     sqrt_start;
   logic [RADICAND_W-1:0]    sqrt_rad;
   logic                     sqrt_done;
   logic [ROOT_W-1:0]        sqrt_root;

   logic [SUM_W-1:0]         sum_mag;
   logic signed [WORD_W:0]   diff;
   logic [WORD_W:0]          diff_neg;
   logic [WORD_W:0]          gain_neg;
   logic [WORD_W-1:0]        mean_mag;
   logic [PM_W-1:0]          pm;
   logic signed [RES_W-1:0]  sprod;
   logic signed [RES_W-1:0]  res;

   // Effective row length and fill tracking
   always_comb begin
      if (row_len_ff == '0) begin
         n_eff = LEN_W'(1);
      end else if (32'(row_len_ff) > MAX_ROW) begin
         n_eff = LEN_W'(MAX_ROW);
      end else begin
         n_eff = LEN_W'(row_len_ff);
      end
      fill_next = LEN_W'(fill_ff) + LEN_W'(1);
      row_done  = (fill_next >= n_eff);
      idx_last  = (LEN_W'(idx_ff) == n_eff - LEN_W'(1));
      sd_zero   = (sd_ff == '0);
   end

   assign req_fire = req_ch.valid && req_ch.ready;
   assign rsp_fire = rsp_ch.valid && rsp_ch.ready;

   // Row store: {offset, gain, sample}
   assign ram_wdata = {sext_dw(req_ch.shift), sext_dw(req_ch.scale), sext_dw(req_ch.sample)};
   assign rd_sample = ram_rdata[WORD_W-1:0];
   assign rd_gain   = ram_rdata[2*WORD_W-1:WORD_W];
   assign rd_off    = ram_rdata[3*WORD_W-1:2*WORD_W];

   lnorm_ram #(
      .WIDTH (RAM_W),
      .DEPTH (MAX_ROW)
   ) u_row_ram (
      .clock   (clock),
      .wr_en   (ram_we),
      .wr_addr (fill_ff),
      .wr_data (ram_wdata),
      .rd_addr (idx_ff),
      .rd_data (ram_rdata)
   );

   // Divider operands by phase
   always_comb begin
      sum_mag = sum_ff[SUM_W-1] ? SUM_W'(-sum_ff) : SUM_W'(sum_ff);
      unique case (state_ff)
         ST_MEAN_GO: begin
            div_dividend = DIVIDEND_W'(sum_mag);
            div_divisor  = DIVISOR_W'(n_eff);
         end
         ST_VDIV_GO: begin
            div_dividend = DIVIDEND_W'(vsum_ff);
            div_divisor  = DIVISOR_W'(n_eff);
         end
         default: begin
            div_dividend = {16'b0, dmag_ff, 16'b0};
            div_divisor  = sd_ff;
         end
      endcase
   end

   lnorm_div u_div (
      .clock    (clock),
      .reset    (reset),
      .start    (div_start),
      .dividend (div_dividend),
      .divisor  (div_divisor),
      .done     (div_done),
      .quotient (div_quo)
   );

   assign sqrt_rad = {var_ff + VAR_W'(eps_ff), 16'b0};

   lnorm_sqrt u_sqrt (
      .clock    (clock),
      .reset    (reset),
      .start    (sqrt_start),
      .radicand (sqrt_rad),
      .done     (sqrt_done),
      .root     (sqrt_root)
   );

   // Next state
   always_comb begin
      state_in = state_ff;
      unique case (state_ff)
         ST_FILL:      if (req_fire && row_done) state_in = ST_SUM_RD;
         ST_SUM_RD:    state_in = ST_SUM_ACC;
         ST_SUM_ACC:   state_in = idx_last ? ST_MEAN_GO : ST_SUM_RD;
         ST_MEAN_GO:   state_in = ST_MEAN_WAIT;
         ST_MEAN_WAIT: if (div_done) state_in = ST_VAR_RD;
         ST_VAR_RD:    state_in = ST_VAR_DIF;
         ST_VAR_DIF:   state_in = ST_VAR_MUL;
         ST_VAR_MUL:   state_in = ST_VAR_ACC;
         ST_VAR_ACC:   state_in = idx_last ? ST_VDIV_GO : ST_VAR_RD;
         ST_VDIV_GO:   state_in = ST_VDIV_WAIT;
         ST_VDIV_WAIT: if (div_done) state_in = ST_SQRT_GO;
         ST_SQRT_GO:   state_in = ST_SQRT_WAIT;
         ST_SQRT_WAIT: if (sqrt_done) state_in = ST_NRM_RD;
         ST_NRM_RD:    state_in = ST_NRM_DIF;
         ST_NRM_DIF:   state_in = ST_NDIV_GO;
         ST_NDIV_GO:   state_in = sd_zero ? ST_NRM_MUL : ST_NDIV_WAIT;
         ST_NDIV_WAIT: if (div_done) state_in = ST_NRM_MUL;
         ST_NRM_MUL:   state_in = ST_NRM_ADD;
         ST_NRM_ADD:   state_in = ST_NRM_OUT;
         ST_NRM_OUT:   if (rsp_fire) state_in = last_ff ? ST_FILL : ST_NRM_RD;
         default:      state_in = ST_FILL;
      endcase
   end

   // Sequencer outputs
   always_comb begin
      req_ch.ready = (state_ff == ST_FILL);
      rsp_ch.valid = (state_ff == ST_NRM_OUT);
      ram_we       = (state_ff == ST_FILL) && req_ch.valid;
      div_start    = (state_ff == ST_MEAN_GO) || (state_ff == ST_VDIV_GO) ||
                     ((state_ff == ST_NDIV_GO) && !sd_zero);
      sqrt_start   = (state_ff == ST_SQRT_GO);
   end

   assign rsp_ch.value = value_ff;
   assign rsp_ch.last  = last_ff;

   // Deviation, gain magnitude and the signed result
   always_comb begin
      diff     = $signed({rd_sample[WORD_W-1], rd_sample}) - $signed({mean_ff[WORD_W-1], mean_ff});
      diff_neg = -diff;
      gain_neg = -{rd_gain[WORD_W-1], rd_gain};
      mean_mag = div_quo[WORD_W-1:0];
      pm       = prod_ff[2*WORD_W-1:16];
      sprod    = (dneg_ff ^ gneg_ff) ? -$signed({2'b00, pm}) : $signed({2'b00, pm});
      res      = sprod + RES_W'(off_ff);
   end

   // Datapath registers
   always_comb begin
      fill_in  = fill_ff;
      idx_in   = idx_ff;
      sum_in   = sum_ff;
      mean_in  = mean_ff;
      dmag_in  = dmag_ff;
      dneg_in  = dneg_ff;
      prod_in  = prod_ff;
      vsum_in  = vsum_ff;
      var_in   = var_ff;
      sd_in    = sd_ff;
      gmag_in  = gmag_ff;
      gneg_in  = gneg_ff;
      off_in   = off_ff;
      nm_in    = nm_ff;
      value_in = value_ff;
      last_in  = last_ff;
      unique case (state_ff)
         ST_FILL: begin
            if (req_fire) begin
               if (row_done) begin
                  fill_in = '0;
                  idx_in  = '0;
                  sum_in  = '0;
               end else begin
                  fill_in = fill_ff + ADDR_W'(1);
               end
            end
         end
         ST_SUM_ACC: begin
            sum_in = sum_ff + SUM_W'($signed(rd_sample));
            idx_in = idx_last ? '0 : idx_ff + ADDR_W'(1);
         end
         ST_MEAN_WAIT: begin
            if (div_done) begin
               mean_in = sum_ff[SUM_W-1] ? -$signed(mean_mag) : $signed(mean_mag);
               vsum_in = '0;
            end
         end
         ST_VAR_DIF: begin
            dmag_in = diff[WORD_W] ? diff_neg[WORD_W-1:0] : diff[WORD_W-1:0];
         end
         ST_VAR_MUL: begin
            prod_in = dmag_ff * dmag_ff;
         end
         ST_VAR_ACC: begin
            vsum_in = vsum_ff + VSUM_W'(prod_ff[2*WORD_W-1:16]);
            idx_in  = idx_last ? '0 : idx_ff + ADDR_W'(1);
         end
         ST_VDIV_WAIT: begin
            if (div_done) var_in = div_quo[VAR_W-1:0];
         end
         ST_SQRT_WAIT: begin
            if (sqrt_done) sd_in = sqrt_root;
         end
         ST_NRM_DIF: begin
            dneg_in = diff[WORD_W];
            dmag_in = diff[WORD_W] ? diff_neg[WORD_W-1:0] : diff[WORD_W-1:0];
            gneg_in = rd_gain[WORD_W-1];
            gmag_in = rd_gain[WORD_W-1] ? gain_neg[WORD_W-1:0] : rd_gain;
            off_in  = $signed(rd_off);
         end
         ST_NDIV_GO: begin
            if (sd_zero) nm_in = '0;
         end
         ST_NDIV_WAIT: begin
            // Quotient saturates to the signed 32-bit range
            if (div_done) begin
               if (dneg_ff) begin
                  nm_in = (div_quo > DIVIDEND_W'(32'h8000_0000)) ?
                          32'h8000_0000 : div_quo[WORD_W-1:0];
               end else begin
                  nm_in = (div_quo > DIVIDEND_W'(32'h7FFF_FFFF)) ?
                          32'h7FFF_FFFF : div_quo[WORD_W-1:0];
               end
            end
         end
         ST_NRM_MUL: begin
            prod_in = nm_ff * gmag_ff;
         end
         ST_NRM_ADD: begin
            if (res > SAT_HI) begin
               value_in = SAT_HI[WORD_W-1:0];
            end else if (res < SAT_LO) begin
               value_in = SAT_LO[WORD_W-1:0];
            end else begin
               value_in = res[WORD_W-1:0];
            end
            last_in = idx_last;
         end
         ST_NRM_OUT: begin
            if (rsp_fire && !last_ff) idx_in = idx_ff + ADDR_W'(1);
         end
         default: begin
         end
      endcase
   end

   // Configuration registers
   always_comb begin
      row_len_in = row_len_ff;
      eps_in     = eps_ff;
      if (csr_we) begin
         if (csr_index == CSR_ROW_LENGTH) row_len_in = csr_wdata[ROWLEN_W-1:0];
         if (csr_index == CSR_EPSILON)    eps_in     = csr_wdata[EPS_W-1:0];
      end
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff   <= ST_FILL;
         row_len_ff <= ROWLEN_RESET;
         eps_ff     <= EPS_RESET;
         fill_ff    <= '0;
         idx_ff     <= '0;
         last_ff    <= 1'b0;
      end else begin
         state_ff   <= state_in;
         row_len_ff <= row_len_in;
         eps_ff     <= eps_in;
         fill_ff    <= fill_in;
         idx_ff     <= idx_in;
         last_ff    <= last_in;
      end
   end

   always_ff @(posedge clock) begin
      sum_ff   <= sum_in;
      mean_ff  <= mean_in;
      dmag_ff  <= dmag_in;
      dneg_ff  <= dneg_in;
      prod_ff  <= prod_in;
      vsum_ff  <= vsum_in;
      var_ff   <= var_in;
      sd_ff    <= sd_in;
      gmag_ff  <= gmag_in;
      gneg_ff  <= gneg_in;
      off_ff   <= off_in;
      nm_ff    <= nm_in;
      value_ff <= value_in;
   end

endmodule

// ----- rtl/lnorm_checker.sv -----
// Port-level checks on the layer normalisation block, bound to its top level.
module lnorm_checker (
   input logic clock,
   input logic reset,
   input logic req_valid,
   input logic req_ready,
   input logic rsp_valid,
   input logic rsp_ready,
   input logic rsp_last
);

   // A pending result transaction is not withdrawn
   a_rsp_hold: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && !rsp_ready |=> rsp_valid)
      else $error("result withdrawn before it was taken");

   // No new element is taken while a result is on offer
   a_no_overlap: assert property (@(posedge clock) disable iff (reset)
      rsp_valid |-> !req_ready)
      else $error("input ready while a result is pending");

   // Reset leaves no result on offer
   a_reset_idle: assert property (@(posedge clock)
      reset |=> !rsp_valid)
      else $error("result valid straight after reset");

   // The last result of a row returns the block to accepting elements
   a_row_end: assert property (@(posedge clock) disable iff (reset)
      rsp_valid && rsp_ready && rsp_last |=> req_ready && !rsp_valid)
      else $error("block not ready for a new row after the last result");

   // An element transaction leaves no result on offer in the next cycle
   a_fill_quiet: assert property (@(posedge clock) disable iff (reset)
      req_valid && req_ready |=> !rsp_valid)
      else $error("result appeared directly after an element was taken");

endmodule

bind layer_normalization lnorm_checker u_lnorm_checker (
   .clock     (clock),
   .reset     (reset),
   .req_valid (req_ch.valid),
   .req_ready (req_ch.ready),
   .rsp_valid (rsp_ch.valid),
   .rsp_ready (rsp_ch.ready),
   .rsp_last  (rsp_ch.last)
);
